// ===== sv/particle_follow_with_pointer_repel_defines.svh =====
// ----------------------------------------------------------------------------
// Particle follow assertion macros
// Shared assertion shorthands for the particle follow pipeline.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_FOLLOW_WITH_POINTER_REPEL_DEFINES_SVH
`define PARTICLE_FOLLOW_WITH_POINTER_REPEL_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PFPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define PFPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/pfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle follow package
// Register indexes, the per-request side data and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package pfpr_pkg;

    localparam int DT_BITS = 16;
    localparam logic [30:0] KD_RESET = 31'd6553600;
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic {
        CFG_POINTER_MODE  = 1'b0,
        CFG_KEEP_DISTANCE = 1'b1
    } t_cfg_index;

    // Side data that rides along the pipeline with each request
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] anc_x;
        logic signed [31:0] anc_y;
        logic signed [15:0] ptr_x;
        logic signed [15:0] ptr_y;
        logic [15:0]        dt;
        logic               sgn_x;
        logic               sgn_y;
        logic [30:0]        mag_x;
        logic [30:0]        mag_y;
        logic               push;
    } t_carry;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // v / 2^DT_BITS, rounded to nearest, ties away from zero
    function automatic logic signed [34:0] rnd_dt(input logic signed [49:0] v);
        logic [50:0] m;
        logic [34:0] q;
        m = v[49] ? 51'(-(51'(v))) : 51'(v);
        q = 35'((m + (51'(1) << (DT_BITS - 1))) >> DT_BITS);
        return v[49] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== sv/particle_follow_with_pointer_repel.sv =====
// Path: stage 1, stage 2, square-root chain, numerators, dividers, f1, f2, output register.
// Throughput: one request per cycle unless the output stalls; the 32-step square-root
// and 32-step divider chains are fully pipelined, one result bit per stage.
// A stall on the output freezes every stage at once.
// Reset (synchronous, active low) clears all valid bits and the mode and radius registers.
// ----------------------------------------------------------------------------
// Particle follow with pointer repel
// Moves a particle toward its drifting anchor, pushing it out of the keep-out
// circle around the pointer first.
// ----------------------------------------------------------------------------
`include "particle_follow_with_pointer_repel_defines.svh"

module particle_follow_with_pointer_repel #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [30:0]         i_cfg_data,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_anchor_x,
    input  logic signed [31:0]  i_anchor_y,
    input  logic signed [31:0]  i_vel_x,
    input  logic signed [31:0]  i_vel_y,
    input  logic [15:0]         i_step_time,
    input  logic signed [15:0]  i_pointer_x,
    input  logic signed [15:0]  i_pointer_y,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_new_pos_x,
    output logic signed [31:0]  o_new_pos_y,
    output logic signed [31:0]  o_new_anchor_x,
    output logic signed [31:0]  o_new_anchor_y,
    output logic                o_was_pushed
);
    import pfpr_pkg::*;

    localparam int PW    = 16 + FRAC_BITS;
    localparam int DXW   = ((PW > 32) ? PW : 32) + 1;
    localparam int NSTEP = 32;

    // ---------------- configuration ----------------
    logic        r_mode;
    logic [30:0] r_kd;
    logic [61:0] r_ksq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_kd   <= KD_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_POINTER_MODE:  r_mode <= i_cfg_data[0];
                CFG_KEEP_DISTANCE: r_kd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squared radius, follows the radius register
    always_ff @(posedge i_clk) begin
        r_ksq <= 62'(r_kd) * 62'(r_kd);
    end

    // ---------------- global advance ----------------
    logic w_adv;
    logic r_o_v;
    assign w_adv   = !r_o_v || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_o_v;

    // ---------------- stage 1: offsets and velocity products ----------------
    logic signed [PW-1:0]  w_ptx, w_pty;
    logic signed [DXW-1:0] w_dx, w_dy;
    logic [DXW-1:0]        w_mx, w_my;
    logic                  w_near;

    assign w_ptx  = {i_pointer_x, {FRAC_BITS{1'b0}}};
    assign w_pty  = {i_pointer_y, {FRAC_BITS{1'b0}}};
    assign w_dx   = DXW'(w_ptx) - DXW'(i_pos_x);
    assign w_dy   = DXW'(w_pty) - DXW'(i_pos_y);
    assign w_mx   = w_dx[DXW-1] ? DXW'(-w_dx) : DXW'(w_dx);
    assign w_my   = w_dy[DXW-1] ? DXW'(-w_dy) : DXW'(w_dy);
    assign w_near = r_mode && (w_mx < DXW'(r_kd)) && (w_my < DXW'(r_kd));

    logic               r1_v;
    t_carry             r1_c;
    logic               r1_near;
    logic signed [48:0] r1_mvx, r1_mvy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_c.pos_x <= i_pos_x;
            r1_c.pos_y <= i_pos_y;
            r1_c.anc_x <= i_anchor_x;
            r1_c.anc_y <= i_anchor_y;
            r1_c.ptr_x <= i_pointer_x;
            r1_c.ptr_y <= i_pointer_y;
            r1_c.dt    <= i_step_time;
            r1_c.sgn_x <= w_dx[DXW-1];
            r1_c.sgn_y <= w_dy[DXW-1];
            r1_c.mag_x <= w_mx[30:0];
            r1_c.mag_y <= w_my[30:0];
            r1_c.push  <= 1'b0;
            r1_near    <= w_near;
            r1_mvx     <= i_vel_x * $signed({1'b0, i_step_time});
            r1_mvy     <= i_vel_y * $signed({1'b0, i_step_time});
        end
    end

    // ---------------- stage 2: squares and new anchor ----------------
    logic        r2_v;
    t_carry      r2_c;
    t_carry      n_c2;
    logic        r2_near;
    logic [61:0] r2_sqx, r2_sqy;

    // side data with the advanced anchor
    always_comb begin
        n_c2       = r1_c;
        n_c2.anc_x = sat32(64'(r1_c.anc_x) + 64'(rnd_dt(50'(r1_mvx))));
        n_c2.anc_y = sat32(64'(r1_c.anc_y) + 64'(rnd_dt(50'(r1_mvy))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_c    <= n_c2;
            r2_near <= r1_near;
            r2_sqx  <= 62'(r1_c.mag_x) * 62'(r1_c.mag_x);
            r2_sqy  <= 62'(r1_c.mag_y) * 62'(r1_c.mag_y);
        end
    end

    // ---------------- stage 3 + square root chain ----------------
    logic [62:0] w_dsq;
    t_carry      n_sq_c;
    assign w_dsq = 63'(r2_sqx) + 63'(r2_sqy);

    // push decision: pointer mode on, strictly inside the circle and off the pointer
    always_comb begin
        n_sq_c      = r2_c;
        n_sq_c.push = r2_near && (w_dsq != '0) && (w_dsq < 63'(r_ksq));
    end

    logic        r_sq_vld [0:NSTEP];
    t_carry      r_sq_c   [0:NSTEP];
    logic [63:0] r_sq_val [0:NSTEP];
    logic [63:0] r_sq_res [0:NSTEP];
    logic [63:0] w_sq_nval [0:NSTEP-1];
    logic [63:0] w_sq_nres [0:NSTEP-1];

    // one result bit per stage: bit = 4^(31-k)
    always_comb begin
        for (int k = 0; k < NSTEP; k++) begin
            if (r_sq_val[k] >= r_sq_res[k] + (64'(1) << (62 - 2 * k))) begin
                w_sq_nval[k] = r_sq_val[k] - (r_sq_res[k] + (64'(1) << (62 - 2 * k)));
                w_sq_nres[k] = (r_sq_res[k] >> 1) + (64'(1) << (62 - 2 * k));
            end else begin
                w_sq_nval[k] = r_sq_val[k];
                w_sq_nres[k] = r_sq_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTEP; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sq_vld[0] <= r2_v;
            for (int k = 0; k < NSTEP; k++) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_c[0]   <= n_sq_c;
            r_sq_val[0] <= 64'(w_dsq);
            r_sq_res[0] <= '0;
            for (int k = 0; k < NSTEP; k++) begin
                r_sq_c[k+1]   <= r_sq_c[k];
                r_sq_val[k+1] <= w_sq_nval[k];
                r_sq_res[k+1] <= w_sq_nres[k];
            end
        end
    end

    // ---------------- numerators ----------------
    logic        rn_v;
    t_carry      rn_c;
    logic [61:0] rn_numx, rn_numy;
    logic [31:0] rn_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_v <= 1'b0;
        end else if (w_adv) begin
            rn_v <= r_sq_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rn_c    <= r_sq_c[NSTEP];
            rn_numx <= 62'(r_sq_c[NSTEP].mag_x) * 62'(r_kd);
            rn_numy <= 62'(r_sq_c[NSTEP].mag_y) * 62'(r_kd);
            rn_dist <= r_sq_res[NSTEP][31:0];
        end
    end

    // ---------------- divider chains (x and y side by side) ----------------
    logic        r_dv_vld [0:NSTEP];
    t_carry      r_dv_c   [0:NSTEP];
    logic [31:0] r_dv_den [0:NSTEP];
    logic [63:0] r_dv_rx  [0:NSTEP];
    logic [63:0] r_dv_ry  [0:NSTEP];
    logic [31:0] r_dv_qx  [0:NSTEP];
    logic [31:0] r_dv_qy  [0:NSTEP];
    logic [63:0] w_dv_rx  [0:NSTEP-1];
    logic [63:0] w_dv_ry  [0:NSTEP-1];
    logic [31:0] w_dv_qx  [0:NSTEP-1];
    logic [31:0] w_dv_qy  [0:NSTEP-1];

    // restoring step: quotient bit 31-k
    always_comb begin
        for (int k = 0; k < NSTEP; k++) begin
            w_dv_rx[k] = r_dv_rx[k];
            w_dv_ry[k] = r_dv_ry[k];
            w_dv_qx[k] = r_dv_qx[k];
            w_dv_qy[k] = r_dv_qy[k];
            if (r_dv_rx[k] >= (64'(r_dv_den[k]) << (NSTEP - 1 - k))) begin
                w_dv_rx[k] = r_dv_rx[k] - (64'(r_dv_den[k]) << (NSTEP - 1 - k));
                w_dv_qx[k][NSTEP-1-k] = 1'b1;
            end
            if (r_dv_ry[k] >= (64'(r_dv_den[k]) << (NSTEP - 1 - k))) begin
                w_dv_ry[k] = r_dv_ry[k] - (64'(r_dv_den[k]) << (NSTEP - 1 - k));
                w_dv_qy[k][NSTEP-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTEP; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_vld[0] <= rn_v;
            for (int k = 0; k < NSTEP; k++) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_c[0]   <= rn_c;
            r_dv_den[0] <= rn_dist;
            r_dv_rx[0]  <= 64'(rn_numx) + 64'(rn_dist >> 1);
            r_dv_ry[0]  <= 64'(rn_numy) + 64'(rn_dist >> 1);
            r_dv_qx[0]  <= '0;
            r_dv_qy[0]  <= '0;
            for (int k = 0; k < NSTEP; k++) begin
                r_dv_c[k+1]   <= r_dv_c[k];
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_rx[k+1]  <= w_dv_rx[k];
                r_dv_ry[k+1]  <= w_dv_ry[k];
                r_dv_qx[k+1]  <= w_dv_qx[k];
                r_dv_qy[k+1]  <= w_dv_qy[k];
            end
        end
    end

    // ---------------- f1: pushed position ----------------
    t_carry             w_dc;
    t_carry             n_f1_c;
    logic signed [63:0] w_pbx, w_pby;
    assign w_dc  = r_dv_c[NSTEP];
    assign w_pbx = 64'(w_dc.ptr_x) <<< FRAC_BITS;
    assign w_pby = 64'(w_dc.ptr_y) <<< FRAC_BITS;

    // pushed particles land on the circle, away from the pointer
    always_comb begin
        n_f1_c = w_dc;
        if (w_dc.push) begin
            n_f1_c.pos_x = sat32(w_dc.sgn_x ? w_pbx + $signed({32'b0, r_dv_qx[NSTEP]})
                                            : w_pbx - $signed({32'b0, r_dv_qx[NSTEP]}));
            n_f1_c.pos_y = sat32(w_dc.sgn_y ? w_pby + $signed({32'b0, r_dv_qy[NSTEP]})
                                            : w_pby - $signed({32'b0, r_dv_qy[NSTEP]}));
        end
    end

    logic   rf1_v;
    t_carry rf1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_v <= 1'b0;
        end else if (w_adv) begin
            rf1_v <= r_dv_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rf1_c <= n_f1_c;
        end
    end

    // ---------------- f2: follow products ----------------
    logic               rf2_v;
    t_carry             rf2_c;
    logic signed [49:0] rf2_px, rf2_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf2_v <= 1'b0;
        end else if (w_adv) begin
            rf2_v <= rf1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rf2_c  <= rf1_c;
            rf2_px <= (33'(rf1_c.anc_x) - 33'(rf1_c.pos_x)) * $signed({1'b0, rf1_c.dt});
            rf2_py <= (33'(rf1_c.anc_y) - 33'(rf1_c.pos_y)) * $signed({1'b0, rf1_c.dt});
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_o_v <= rf2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_new_pos_x    <= sat32(64'(rf2_c.pos_x) + 64'(rnd_dt(rf2_px)));
            o_new_pos_y    <= sat32(64'(rf2_c.pos_y) + 64'(rnd_dt(rf2_py)));
            o_new_anchor_x <= rf2_c.anc_x;
            o_new_anchor_y <= rf2_c.anc_y;
            o_was_pushed   <= rf2_c.push;
        end
    end

    // ---------------- assertions ----------------
    logic w_sq_push, w_dv_push, w_dv_rem_ok;
    assign w_sq_push   = r_sq_vld[NSTEP] && r_sq_c[NSTEP].push;
    assign w_dv_push   = r_dv_vld[NSTEP] && w_dc.push;
    assign w_dv_rem_ok = (r_dv_rx[NSTEP] < 64'(r_dv_den[NSTEP]))
                      && (r_dv_ry[NSTEP] < 64'(r_dv_den[NSTEP]));

    // a pushed particle has a nonzero distance
    `PFPR_ASSERT_IMP(a_dist_nonzero, i_clk, i_rst_n, w_sq_push, r_sq_res[NSTEP][31:0] != '0)
    // distance stays below the largest radius
    `PFPR_ASSERT_IMP(a_dist_range, i_clk, i_rst_n, w_sq_push, r_sq_res[NSTEP][63:31] == '0)
    // both quotients fit: remainders end below the divisor
    `PFPR_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, w_dv_push, w_dv_rem_ok)

endmodule
